// File: hw/rtl/dqpb_pkg.sv
// Shared definitions for the DNS query packet builder: sizes, register indexes,
// microcode control word types and the microcode program itself.
// Depends on nothing; imported by the builder top level.
package dqpb_pkg;

	localparam int LABEL_DEPTH = 32;
	localparam int LABEL_AW    = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1;
	localparam int COUNT_W     = 6;
	localparam int PC_W        = 5;
	localparam int REG_W       = 16;
	localparam int REG_IDX_W   = 2;

	localparam logic [7:0] DOT_CHAR = 8'h2E;

	typedef logic [PC_W-1:0] pc_t;

	// Configuration register indexes.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_QUERY_ID    = 2'd0,
		REG_QUERY_TYPE  = 2'd1,
		REG_QUERY_CLASS = 2'd2
	} reg_idx_t;

	// Byte source selected by a control word.
	typedef enum logic [3:0] {
		SRC_CONST,
		SRC_ID_HI,
		SRC_ID_LO,
		SRC_LEN,
		SRC_CHR,
		SRC_TYPE_HI,
		SRC_TYPE_LO,
		SRC_CLASS_HI,
		SRC_CLASS_LO
	} src_t;

	// How the end-of-run and end-of-message flags are formed.
	typedef enum logic [1:0] {
		END_NONE,
		END_HDR,
		END_LBL,
		END_MSG
	} end_t;

	// Side effect on the builder state when a step completes.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_SET_HDR,
		OP_CHAR,
		OP_CLR_LABEL,
		OP_CLR_HDR
	} op_t;

	// Sequencing of the step counter.
	typedef enum logic [2:0] {
		BR_NEXT,
		BR_IDLE,
		BR_PROC,
		BR_EMPTY,
		BR_CHR,
		BR_LAST,
		BR_ALWAYS
	} br_t;

	typedef struct packed {
		logic       emit;
		src_t       src;
		logic [7:0] konst;
		logic       use_trunc;
		end_t       fin;
		op_t        op;
		br_t        br;
		pc_t        target;
	} uc_word_t;

	// Program entry points.
	localparam pc_t P_IDLE  = 5'd0;
	localparam pc_t P_PROC  = 5'd13;
	localparam pc_t P_AFTER = 5'd16;

	// The microcode program. Steps 1 to 12 send the header, step 13 handles
	// the character, 14 to 16 flush the buffered label, 17 to 21 the trailer.
	function automatic uc_word_t uc_rom(pc_t pc);
		uc_word_t w;
		case (pc)
			5'd0:  w = '{1'b0, SRC_CONST,    8'h00, 1'b0, END_NONE, OP_NONE,      BR_IDLE,   P_PROC};
			5'd1:  w = '{1'b1, SRC_ID_HI,    8'h00, 1'b0, END_NONE, OP_NONE,      BR_NEXT,   P_IDLE};
			5'd2:  w = '{1'b1, SRC_ID_LO,    8'h00, 1'b0, END_NONE, OP_NONE,      BR_NEXT,   P_IDLE};
			5'd3:  w = '{1'b1, SRC_CONST,    8'h01, 1'b0, END_NONE, OP_NONE,      BR_NEXT,   P_IDLE};
			5'd4:  w = '{1'b1, SRC_CONST,    8'h00, 1'b0, END_NONE, OP_NONE,      BR_NEXT,   P_IDLE};
			5'd5:  w = '{1'b1, SRC_CONST,    8'h00, 1'b0, END_NONE, OP_NONE,      BR_NEXT,   P_IDLE};
			5'd6:  w = '{1'b1, SRC_CONST,    8'h01, 1'b0, END_NONE, OP_NONE,      BR_NEXT,   P_IDLE};
			5'd7:  w = '{1'b1, SRC_CONST,    8'h00, 1'b0, END_NONE, OP_NONE,      BR_NEXT,   P_IDLE};
			5'd8:  w = '{1'b1, SRC_CONST,    8'h00, 1'b0, END_NONE, OP_NONE,      BR_NEXT,   P_IDLE};
			5'd9:  w = '{1'b1, SRC_CONST,    8'h00, 1'b0, END_NONE, OP_NONE,      BR_NEXT,   P_IDLE};
			5'd10: w = '{1'b1, SRC_CONST,    8'h00, 1'b0, END_NONE, OP_NONE,      BR_NEXT,   P_IDLE};
			5'd11: w = '{1'b1, SRC_CONST,    8'h00, 1'b0, END_NONE, OP_NONE,      BR_NEXT,   P_IDLE};
			5'd12: w = '{1'b1, SRC_CONST,    8'h00, 1'b0, END_HDR,  OP_SET_HDR,   BR_NEXT,   P_IDLE};
			5'd13: w = '{1'b0, SRC_CONST,    8'h00, 1'b0, END_NONE, OP_CHAR,      BR_PROC,   P_IDLE};
			5'd14: w = '{1'b1, SRC_LEN,      8'h00, 1'b1, END_NONE, OP_NONE,      BR_EMPTY,  P_AFTER};
			5'd15: w = '{1'b1, SRC_CHR,      8'h00, 1'b1, END_LBL,  OP_NONE,      BR_CHR,    P_IDLE};
			5'd16: w = '{1'b0, SRC_CONST,    8'h00, 1'b0, END_NONE, OP_CLR_LABEL, BR_LAST,   P_IDLE};
			5'd17: w = '{1'b1, SRC_CONST,    8'h00, 1'b0, END_NONE, OP_NONE,      BR_NEXT,   P_IDLE};
			5'd18: w = '{1'b1, SRC_TYPE_HI,  8'h00, 1'b0, END_NONE, OP_NONE,      BR_NEXT,   P_IDLE};
			5'd19: w = '{1'b1, SRC_TYPE_LO,  8'h00, 1'b0, END_NONE, OP_NONE,      BR_NEXT,   P_IDLE};
			5'd20: w = '{1'b1, SRC_CLASS_HI, 8'h00, 1'b0, END_NONE, OP_NONE,      BR_NEXT,   P_IDLE};
			5'd21: w = '{1'b1, SRC_CLASS_LO, 8'h00, 1'b0, END_MSG,  OP_CLR_HDR,   BR_ALWAYS, P_IDLE};
			default: w = '{1'b0, SRC_CONST,  8'h00, 1'b0, END_NONE, OP_NONE,      BR_ALWAYS, P_IDLE};
		endcase
		return w;
	endfunction

endpackage

// File: hw/rtl/dqpb_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// Self-contained; used for the label buffer of the DNS query packet builder.
module dqpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/dns_query_packet_builder.sv
// DNS query packet builder top level: microcoded sequencer, label buffer RAM
// and the output register. Depends on dqpb_pkg and dqpb_ram.
//
// Usage: the domain name enters one character per item on the input channel
// (name_char, final_char marking the last one) with valid/ready handshake.
// The query message leaves one byte per item on the output channel, with
// run_end on the last byte caused by an input item, message_end on the final
// byte of the message and label_truncated on the bytes of a cut label. The
// user must write the configuration (query_id, query_type, query_class) through the
// cfg_wr_en / cfg_index / cfg_wdata port while the block is idle; the block does not enforce this.
//
// Timing: a small microcode program steps once per clock unless a byte step
// waits on the output. A plain character is accepted and then buffered. The
// first character of a message adds the steps that send the twelve header
// bytes; a dot or last character adds the length byte step, one character
// step per label byte and the control step that clears the label (an empty
// label sends no length byte but still passes through the length and control
// steps), and the last character adds the steps for the five trailer bytes.
// A receiver stall freezes the program on its current byte step; the held
// output byte stays put until it is taken. After reset the configuration
// registers hold their defaults, no header has been sent and the label is empty.
module dns_query_packet_builder
	import dqpb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           name_char,
	input  logic                 final_char,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 run_end,
	output logic                 message_end,
	output logic                 label_truncated,

	input  logic                 cfg_wr_en,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_wdata
);

	// Configuration registers.
	logic [REG_W-1:0] query_id_q;
	logic [REG_W-1:0] query_type_q;
	logic [REG_W-1:0] query_class_q;

	// Sequencer and builder state.
	pc_t                pc_q;
	pc_t                pc_nxt;
	logic [7:0]         ch_q;
	logic               last_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] rd_idx_q;
	logic               hdr_sent_q;
	logic               ovf_q;

	// Output register.
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               run_end_q;
	logic               message_end_q;
	logic               trunc_q;

	uc_word_t           uw;
	logic               is_dot;
	logic               cnt_zero;
	logic               emit_req;
	logic               slot_free;
	logic               fire;
	logic               accept;
	logic               room;
	logic [7:0]         byte_sel;
	logic               run_end_sel;

	logic               ram_we;
	logic               ram_re;
	logic [LABEL_AW-1:0] ram_raddr;
	logic [7:0]         ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_id_q    <= 16'hAAAA;
			query_type_q  <= 16'h0001;
			query_class_q <= 16'h0001;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_QUERY_ID:    query_id_q    <= cfg_wdata;
				REG_QUERY_TYPE:  query_type_q  <= cfg_wdata;
				REG_QUERY_CLASS: query_class_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign uw        = uc_rom(pc_q);
	assign is_dot    = (ch_q == DOT_CHAR);
	assign cnt_zero  = (count_q == '0);
	assign room      = (count_q < COUNT_W'(LABEL_DEPTH));
	assign in_ready  = (uw.br == BR_IDLE);
	assign accept    = in_valid && in_ready;
	// An empty label sends no length byte, so that step does not wait.
	assign emit_req  = uw.emit && !(uw.br == BR_EMPTY && cnt_zero);
	assign slot_free = !out_valid_q || out_ready;
	assign fire      = !emit_req || slot_free;

	always_comb begin
		case (uw.src)
			SRC_CONST:    byte_sel = uw.konst;
			SRC_ID_HI:    byte_sel = query_id_q[15:8];
			SRC_ID_LO:    byte_sel = query_id_q[7:0];
			SRC_LEN:      byte_sel = 8'(count_q);
			SRC_CHR:      byte_sel = ram_rdata;
			SRC_TYPE_HI:  byte_sel = query_type_q[15:8];
			SRC_TYPE_LO:  byte_sel = query_type_q[7:0];
			SRC_CLASS_HI: byte_sel = query_class_q[15:8];
			SRC_CLASS_LO: byte_sel = query_class_q[7:0];
			default:      byte_sel = 8'h00;
		endcase
	end

	// The last header byte ends the run unless a non-empty label flush or the trailer follows.
	// The last label character ends it unless the trailer follows.
	always_comb begin
		case (uw.fin)
			END_HDR: run_end_sel = !last_q && !(is_dot && !cnt_zero);
			END_LBL: run_end_sel = !last_q && (rd_idx_q == count_q);
			END_MSG: run_end_sel = 1'b1;
			default: run_end_sel = 1'b0;
		endcase
	end

	always_comb begin
		case (uw.br)
			BR_NEXT:   pc_nxt = pc_q + 5'd1;
			BR_IDLE:   pc_nxt = accept ? (hdr_sent_q ? uw.target : pc_q + 5'd1) : pc_q;
			BR_PROC:   pc_nxt = (is_dot || last_q) ? pc_q + 5'd1 : uw.target;
			BR_EMPTY:  pc_nxt = cnt_zero ? uw.target : pc_q + 5'd1;
			BR_CHR:    pc_nxt = (rd_idx_q == count_q) ? pc_q + 5'd1 : pc_q;
			BR_LAST:   pc_nxt = last_q ? pc_q + 5'd1 : uw.target;
			BR_ALWAYS: pc_nxt = uw.target;
			default:   pc_nxt = P_IDLE;
		endcase
	end

	// The label read is issued one step ahead: the length byte step fetches
	// the first character and each character step fetches the next one.
	assign ram_we    = fire && (uw.op == OP_CHAR) && !is_dot && room;
	assign ram_re    = fire && (((uw.br == BR_EMPTY) && !cnt_zero) ||
	                            ((uw.br == BR_CHR) && (rd_idx_q < count_q)));
	assign ram_raddr = (uw.br == BR_CHR) ? rd_idx_q[LABEL_AW-1:0] : '0;

	dqpb_ram #(
		.WIDTH(8),
		.DEPTH(LABEL_DEPTH)
	) u_label_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[LABEL_AW-1:0]),
		.wdata (ch_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= P_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			hdr_sent_q  <= 1'b0;
			ovf_q       <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				last_q <= final_char;
			end
			if (fire) begin
				pc_q <= pc_nxt;
				case (uw.op)
					OP_SET_HDR: hdr_sent_q <= 1'b1;
					OP_CLR_HDR: hdr_sent_q <= 1'b0;
					OP_CHAR: begin
						if (!is_dot) begin
							if (room) begin
								count_q <= count_q + 6'd1;
							end else begin
								ovf_q <= 1'b1;
							end
						end
					end
					OP_CLR_LABEL: begin
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
					default: ;
				endcase
				if (uw.br == BR_EMPTY) begin
					rd_idx_q <= 6'd1;
				end else if (uw.br == BR_CHR) begin
					rd_idx_q <= rd_idx_q + 6'd1;
				end
			end
			if (emit_req && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q <= name_char;
		end
		if (emit_req && slot_free) begin
			out_byte_q    <= byte_sel;
			run_end_q     <= run_end_sel;
			message_end_q <= (uw.fin == END_MSG);
			trunc_q       <= uw.use_trunc && ovf_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_byte        = out_byte_q;
	assign run_end         = run_end_q;
	assign message_end     = message_end_q;
	assign label_truncated = trunc_q;

endmodule
